@@ hdl/keyboard_typematic_repeat_unit_assert.svh @@
// Assertion macros shared by the typematic repeat unit.
`ifndef KEYBOARD_TYPEMATIC_REPEAT_UNIT_ASSERT_SVH
`define KEYBOARD_TYPEMATIC_REPEAT_UNIT_ASSERT_SVH
`define KTR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ktr assertion failed");
`define KTR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ktr assertion failed");
`endif

@@ hdl/ktr_pkg.sv @@
// Package with types, constants and the key class table of the typematic repeat unit.
package ktr_pkg;
  localparam int unsigned NUM_KEYS    = 93;
  localparam int unsigned TIME_BITS   = 32;
  localparam int unsigned MAX_REPEATS = 16;
  localparam int unsigned RESULT_LIMIT = 16;
  localparam int unsigned REPEAT_CAP  = (MAX_REPEATS < RESULT_LIMIT) ? MAX_REPEATS : RESULT_LIMIT;
  localparam int unsigned CNT_W       = $clog2(REPEAT_CAP + 1);
  localparam int unsigned STEP_W      = $clog2(NUM_KEYS);
  localparam int unsigned CODE_W      = 7;
  localparam int unsigned CFG_W       = 16;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CODE_CTRL   = 48;
  localparam int unsigned CODE_ALT    = 49;
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd1;
  localparam logic [1:0] CLASS_NONE = 2'd0;
  localparam logic [1:0] CLASS_CHAR = 2'd1;
  localparam logic [1:0] CLASS_SYS  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PASS1, ST_PASS2, ST_DIV, ST_EMIT
  } state_e;

  typedef struct packed {
    logic                 prev;
    logic                 cur;
    logic                 armed;
    logic [TIME_BITS-1:0] deadline;
  } cell_t;

  function automatic logic [1:0] key_class(input logic [STEP_W-1:0] code);
    logic [1:0] c;
    c = CLASS_NONE;
    case (code) inside
      [7'd13:7'd24], 7'd38, [7'd40:7'd46], [7'd50:7'd77]: c = CLASS_CHAR;
      7'd25, 7'd26, 7'd29, [7'd34:7'd37]:                  c = CLASS_SYS;
      default:                                             c = CLASS_NONE;
    endcase
    return c;
  endfunction
endpackage

@@ hdl/ktr_cell.sv @@
// One key cell of the state ring: down bits, armed flag and repeat deadline.
module ktr_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          shift_i,
  input  logic          load_i,
  input  logic          cur_i,
  input  logic          clr_arm_i,
  input  ktr_pkg::cell_t nb_i,
  output ktr_pkg::cell_t st_o
);
  import ktr_pkg::*;

  logic prev_q, cur_q, armed_q;
  logic [TIME_BITS-1:0] deadline_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= 1'b0;
      cur_q   <= 1'b0;
      armed_q <= 1'b0;
    end else if (shift_i) begin
      prev_q  <= nb_i.prev;
      cur_q   <= nb_i.cur;
      armed_q <= nb_i.armed;
    end else if (load_i) begin
      cur_q   <= cur_i;
      armed_q <= armed_q & ~clr_arm_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      deadline_q <= nb_i.deadline;
    end
  end

  assign st_o = '{prev: prev_q, cur: cur_q, armed: armed_q, deadline: deadline_q};
endmodule

@@ hdl/ktr_repeat_div.sv @@
// Repeat counter: one plus the quotient of elapsed time by period, capped at REPEAT_CAP, by repeated subtraction.
module ktr_repeat_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ktr_pkg::TIME_BITS-1:0] diff_i,
  input  logic [ktr_pkg::CFG_W-1:0]     period_i,
  output logic                          busy_o,
  output logic [ktr_pkg::CNT_W-1:0]     count_o,
  output logic [ktr_pkg::TIME_BITS-1:0] adv_o
);
  import ktr_pkg::*;

  logic                 busy_q, busy_d;
  logic [TIME_BITS-1:0] rem_q, rem_d, adv_q, adv_d, per_q, per_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 more;

  assign more = (rem_q >= per_q) && (cnt_q < CNT_W'(REPEAT_CAP));

  always_comb begin
    busy_d = busy_q;
    rem_d  = rem_q;
    adv_d  = adv_q;
    per_d  = per_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      rem_d  = diff_i;
      per_d  = TIME_BITS'(period_i);
      adv_d  = TIME_BITS'(period_i);
      cnt_d  = CNT_W'(1);
    end else if (busy_q) begin
      if (more) begin
        rem_d = rem_q - per_q;
        adv_d = adv_q + per_q;
        cnt_d = cnt_q + CNT_W'(1);
      end else begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    adv_q <= adv_d;
    per_q <= per_d;
    cnt_q <= cnt_d;
  end

  assign busy_o  = busy_q;
  assign count_o = cnt_q;
  assign adv_o   = adv_q;
endmodule

@@ hdl/keyboard_typematic_repeat_unit.sv @@
// Typematic repeat unit: a ring of key cells walked twice per scan by one head stage.
// A scan is taken only in idle and then walks the ring twice; result stalls hold the walk.
// A press event is emitted in the first pass when the walk reaches the newly pressed key.
// A repeating key adds a counter start, the counter run and one repeat event per count.
// Reset clears all keys to up and disarmed, delay 400, period 40.
module keyboard_typematic_repeat_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ktr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ktr_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [63:0]                   keys_low_i,
  input  logic [28:0]                   keys_high_i,
  input  logic                          scan_ok_i,
  input  logic [31:0]                   time_now_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [6:0]                    key_code_o,
  output logic                          sys_char_o,
  output logic                          last_event_o
);
  import ktr_pkg::*;

  state_e state_q, state_d;
  logic [CFG_W-1:0]     delay_q, period_q, period_eff;
  logic [STEP_W-1:0]    step_q, hidx_q;
  logic                 found_q, fired_q, sys_q;
  logic [CNT_W-1:0]     e_q;
  logic [TIME_BITS-1:0] now_q, diff;
  logic                 out_valid_q, out_sys_q, out_last_q;
  logic [CODE_W-1:0]    out_code_q;
  cell_t                cells [NUM_KEYS];
  cell_t                head, head_n;
  logic [NUM_KEYS-1:0]  keys;
  logic [1:0]           cls;
  logic accept, out_free, shift, div_start, emit, emit_last, set_found, set_fired, clr_all;
  logic last_step, div_busy;
  logic [CNT_W-1:0]     div_cnt;
  logic [TIME_BITS-1:0] div_adv;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign keys       = {keys_high_i, keys_low_i};
  assign head       = cells[0];
  assign cls        = key_class(step_q);
  assign last_step  = (step_q == STEP_W'(NUM_KEYS - 1));
  assign period_eff = (period_q == '0) ? CFG_W'(1) : period_q;
  assign diff       = now_q - head.deadline;
  assign clr_all    = (cells[CODE_CTRL].prev && !(scan_ok_i ? keys[CODE_CTRL] : 1'b1)) ||
                      (cells[CODE_ALT].prev && !(scan_ok_i ? keys[CODE_ALT] : 1'b1));

  for (genvar i = 0; i < NUM_KEYS; i++) begin : g_cell
    cell_t nb;
    if (i == NUM_KEYS - 1) begin : g_tail
      assign nb = head_n;
    end else begin : g_mid
      assign nb = cells[i+1];
    end
    ktr_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .shift_i  (shift),
      .load_i   (accept),
      .cur_i    (scan_ok_i ? keys[i] : cells[i].prev),
      .clr_arm_i(clr_all),
      .nb_i     (nb),
      .st_o     (cells[i])
    );
  end

  ktr_repeat_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .diff_i  (diff),
    .period_i(period_eff),
    .busy_o  (div_busy),
    .count_o (div_cnt),
    .adv_o   (div_adv)
  );

  always_comb begin
    head_n    = head;
    shift     = 1'b0;
    div_start = 1'b0;
    emit      = 1'b0;
    emit_last = 1'b0;
    set_found = 1'b0;
    set_fired = 1'b0;
    unique case (state_q)
      ST_PASS1: begin
        if (cls != CLASS_NONE && !head.prev && head.cur && !found_q) begin
          if (out_free) begin
            head_n.armed    = 1'b1;
            head_n.deadline = now_q + TIME_BITS'(delay_q);
            shift     = 1'b1;
            emit      = 1'b1;
            emit_last = 1'b1;
            set_found = 1'b1;
          end
        end else begin
          shift = 1'b1;
        end
      end
      ST_PASS2: begin
        head_n.prev = head.cur;
        if (found_q) begin
          if (cls != CLASS_NONE && step_q != hidx_q) head_n.armed = 1'b0;
          shift = 1'b1;
        end else if (cls != CLASS_NONE && ((head.prev && !head.cur) || fired_q)) begin
          head_n.armed = 1'b0;
          shift = 1'b1;
        end else if (cls != CLASS_NONE && head.armed && !diff[TIME_BITS-1]) begin
          div_start = 1'b1;
        end else begin
          shift = 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_last = (e_q == div_cnt);
          if (e_q == div_cnt) begin
            head_n.prev     = head.cur;
            head_n.deadline = head.deadline + div_adv;
            shift     = 1'b1;
            set_fired = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept) state_d = ST_PASS1;
      ST_PASS1: if (shift && last_step) state_d = ST_PASS2;
      ST_PASS2: begin
        if (div_start) state_d = ST_DIV;
        else if (shift && last_step) state_d = ST_IDLE;
      end
      ST_DIV:   if (!div_busy) state_d = ST_EMIT;
      ST_EMIT: begin
        if (shift) state_d = last_step ? ST_IDLE : ST_PASS2;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      delay_q     <= CFG_W'(400);
      period_q    <= CFG_W'(40);
      step_q      <= '0;
      found_q     <= 1'b0;
      fired_q     <= 1'b0;
      e_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_DELAY:  delay_q  <= cfg_data_i;
          CFG_PERIOD: period_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept) begin
        step_q  <= '0;
        found_q <= 1'b0;
        fired_q <= 1'b0;
      end else begin
        if (shift) step_q <= last_step ? '0 : step_q + STEP_W'(1);
        if (set_found) found_q <= 1'b1;
        if (set_fired) fired_q <= 1'b1;
      end
      if (state_q == ST_DIV) e_q <= CNT_W'(1);
      else if (emit) e_q <= e_q + CNT_W'(1);
      if (emit) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      now_q <= time_now_i;
      sys_q <= scan_ok_i ? (keys[CODE_CTRL] | keys[CODE_ALT])
                         : (cells[CODE_CTRL].prev | cells[CODE_ALT].prev);
    end
    if (set_found) hidx_q <= step_q;
    if (emit) begin
      out_code_q <= CODE_W'(step_q);
      out_sys_q  <= sys_q || (cls == CLASS_SYS);
      out_last_q <= emit_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign key_code_o   = out_code_q;
  assign sys_char_o   = out_sys_q;
  assign last_event_o = out_last_q;

`include "keyboard_typematic_repeat_unit_assert.svh"
  `KTR_ASSERT_IMPL(a_div_in_state, div_busy, state_q == ST_DIV)
  `KTR_ASSERT_NEXT(a_accept_walk, accept, state_q == ST_PASS1 && step_q == '0)
  `KTR_ASSERT_IMPL(a_emit_count, state_q == ST_EMIT, e_q != '0 && e_q <= div_cnt)
  `KTR_ASSERT_IMPL(a_one_fire, set_fired, !fired_q && !found_q)
endmodule
